/* rtl/firmware_block_upload_sender_macros.svh */
// Assertion macros for the upload sender.
`ifndef FIRMWARE_BLOCK_UPLOAD_SENDER_MACROS_SVH
`define FIRMWARE_BLOCK_UPLOAD_SENDER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Condition holds in the same cycle as the trigger.
`define FBUS_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("assertion failed");
// Condition holds in the cycle after the trigger.
`define FBUS_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("assertion failed");
`else
`define FBUS_ASSERT_SAME(lbl, trig, cond)
`define FBUS_ASSERT_NEXT(lbl, trig, cond)
`endif

`endif

/* rtl/fbus_pkg.sv */
package fbus_pkg;

  // Packet payload size; must be a power of two.
  localparam int CHUNK_BYTES = 2048;
  localparam int CHUNK_LOG2  = $clog2(CHUNK_BYTES);
  localparam int POS_W       = $clog2(CHUNK_BYTES + 4);
  localparam int LEN_W       = $clog2(CHUNK_BYTES + 1);
  localparam int PKT_W       = 32 - CHUNK_LOG2;
  localparam int CMD_LEN     = 15;
  localparam int CFG_IDX_W   = 1;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_SLOT  = 3'd1;
  localparam logic [2:0] OP_FILE  = 3'd2;
  localparam logic [2:0] OP_ACK   = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SENDING = 3'd1;
  localparam logic [2:0] ST_WAITING = 3'd2;
  localparam logic [2:0] ST_SUCCESS = 3'd3;
  localparam logic [2:0] ST_FAILED  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_BAUD_WORD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 1'd1;

  localparam logic [31:0] BAUD_RESET    = 32'd460800;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

  localparam logic [7:0] BYTE_ACK  = 8'hAA;
  localparam logic [7:0] BYTE_SYNC = 8'hEE;
  localparam logic [7:0] BYTE_CMD  = 8'hF1;
  localparam logic [7:0] BYTE_TAIL = 8'hFC;
  localparam logic [7:0] BYTE_FILL = 8'hFF;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CMD,
    PH_PKT,
    PH_WAIT,
    PH_OK,
    PH_FAIL
  } phase_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] file_size;
    logic [7:0]  data_byte;
    logic [7:0]  rx_first;
    logic [7:0]  rx_second;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        want_file_byte;
    logic [2:0]  status;
    logic [7:0]  frame_number;
  } out_item_t;

endpackage

/* rtl/fbus_in_if.sv */
interface fbus_in_if;
  logic              valid;
  logic              ready;
  fbus_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/fbus_out_if.sv */
interface fbus_out_if;
  logic               valid;
  logic               ready;
  fbus_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/firmware_block_upload_sender.sv */
// The result is registered at the edge where its item transfers
// and is offered on the output channel from the next cycle.
// Throughput: one item per cycle; an item is taken whenever the output register is
// empty or its result transfers in the same cycle, so only output stalls slow it.
// Reset: synchronous, active low; clears the upload state and loads the register
// defaults. No memory, no clearing pass.
`include "firmware_block_upload_sender_macros.svh"

module firmware_block_upload_sender (
  input  logic                                 clk,
  input  logic                                 rst_n,
  fbus_in_if.sink                              in_ch,
  fbus_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [fbus_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_wdata
);

  localparam int POS_W      = fbus_pkg::POS_W;
  localparam int LEN_W      = fbus_pkg::LEN_W;
  localparam int PKT_W      = fbus_pkg::PKT_W;
  localparam int CHUNK_LOG2 = fbus_pkg::CHUNK_LOG2;

  localparam logic [POS_W-1:0] POS_CMD_END = POS_W'(fbus_pkg::CMD_LEN);
  localparam logic [POS_W-1:0] POS_SUM_HI  = POS_W'(fbus_pkg::CHUNK_BYTES + 2);
  localparam logic [POS_W-1:0] POS_SUM_LO  = POS_W'(fbus_pkg::CHUNK_BYTES + 3);
  localparam logic [LEN_W-1:0] LEN_FULL    = LEN_W'(fbus_pkg::CHUNK_BYTES);

  // configuration
  logic [31:0] baud_r;
  logic [15:0] timeout_r;

  // upload state
  fbus_pkg::phase_t         phase_r, phase_nxt;
  logic [7:0]               frame_r, frame_nxt;
  logic [PKT_W:0]           sent_r, sent_nxt;
  logic [PKT_W-1:0]         full_r, full_nxt;
  logic [CHUNK_LOG2-1:0]    rem_r, rem_nxt;
  logic [31:0]              size_r, size_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [15:0]              sum_r, sum_nxt;
  logic [15:0]              timer_r, timer_nxt;

  logic                     tx_valid_nxt;
  logic [7:0]               tx_byte_nxt;

  logic                     out_valid_r;
  fbus_pkg::out_item_t      out_r, out_nxt;

  logic                     in_fire;
  logic                     due_now;
  logic                     due_nxt;
  logic [7:0]               cmd_sum;
  logic [7:0]               cmd_byte;
  logic [7:0]               nf;
  logic                     ack_ok;
  logic [7:0]               slot_byte;

  logic                     out_st_send;
  logic                     out_st_busy;
  logic                     ack_idle_fire;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  function automatic logic file_due(fbus_pkg::phase_t ph, logic [POS_W-1:0] p,
                                    logic [LEN_W-1:0] l);
    logic [POS_W-1:0] off;
    off = p - POS_W'(2);
    return (ph == fbus_pkg::PH_PKT) && (p >= POS_W'(2)) && (off < POS_W'(l));
  endfunction

  assign due_now = file_due(phase_r, pos_r, len_r);

  // command frame checksum over bytes 1..9
  assign cmd_sum = fbus_pkg::BYTE_CMD
                 + size_r[31:24] + size_r[23:16] + size_r[15:8] + size_r[7:0]
                 + baud_r[31:24] + baud_r[23:16] + baud_r[15:8] + baud_r[7:0];

  always_comb begin
    case (pos_r[3:0])
      4'd0:    cmd_byte = fbus_pkg::BYTE_SYNC;
      4'd1:    cmd_byte = fbus_pkg::BYTE_CMD;
      4'd2:    cmd_byte = size_r[31:24];
      4'd3:    cmd_byte = size_r[23:16];
      4'd4:    cmd_byte = size_r[15:8];
      4'd5:    cmd_byte = size_r[7:0];
      4'd6:    cmd_byte = baud_r[31:24];
      4'd7:    cmd_byte = baud_r[23:16];
      4'd8:    cmd_byte = baud_r[15:8];
      4'd9:    cmd_byte = baud_r[7:0];
      4'd10:   cmd_byte = cmd_sum;
      4'd12:   cmd_byte = fbus_pkg::BYTE_TAIL;
      default: cmd_byte = fbus_pkg::BYTE_FILL;
    endcase
  end

  always_comb begin
    if (pos_r == '0) begin
      slot_byte = frame_r;
    end else if (pos_r == POS_W'(1)) begin
      slot_byte = ~frame_r;
    end else if (pos_r < POS_SUM_HI) begin
      slot_byte = 8'h00;
    end else if (pos_r == POS_SUM_HI) begin
      slot_byte = ~sum_r[15:8];
    end else begin
      slot_byte = ~sum_r[7:0];
    end
  end

  assign nf     = frame_r + 8'd1;
  assign ack_ok = (in_ch.data.rx_first == fbus_pkg::BYTE_ACK) ||
                  ((in_ch.data.rx_first == nf) && (in_ch.data.rx_second == ~nf));

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    frame_nxt    = frame_r;
    sent_nxt     = sent_r;
    full_nxt     = full_r;
    rem_nxt      = rem_r;
    size_nxt     = size_r;
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    sum_nxt      = sum_r;
    timer_nxt    = timer_r;
    tx_valid_nxt = 1'b0;
    tx_byte_nxt  = 8'h00;

    case (in_ch.data.operation)
      fbus_pkg::OP_START: begin
        size_nxt  = in_ch.data.file_size;
        full_nxt  = in_ch.data.file_size[31:CHUNK_LOG2];
        rem_nxt   = in_ch.data.file_size[CHUNK_LOG2-1:0];
        frame_nxt = 8'd0;
        sent_nxt  = '0;
        pos_nxt   = '0;
        len_nxt   = '0;
        sum_nxt   = 16'd0;
        timer_nxt = 16'd0;
        phase_nxt = fbus_pkg::PH_CMD;
      end
      fbus_pkg::OP_SLOT: begin
        if (phase_r == fbus_pkg::PH_CMD) begin
          tx_valid_nxt = 1'b1;
          tx_byte_nxt  = cmd_byte;
          pos_nxt      = pos_r + POS_W'(1);
          if (pos_nxt >= POS_CMD_END) begin
            phase_nxt = fbus_pkg::PH_WAIT;
            timer_nxt = 16'd0;
          end
        end else if (phase_r == fbus_pkg::PH_PKT && !due_now) begin
          tx_valid_nxt = 1'b1;
          tx_byte_nxt  = slot_byte;
          if (pos_r < POS_SUM_HI) begin
            sum_nxt = sum_r + {8'h00, slot_byte};
          end
          pos_nxt = pos_r + POS_W'(1);
          if (pos_r >= POS_SUM_LO) begin
            sent_nxt  = sent_r + (PKT_W+1)'(1);
            phase_nxt = fbus_pkg::PH_WAIT;
            timer_nxt = 16'd0;
          end
        end
      end
      fbus_pkg::OP_FILE: begin
        if (due_now) begin
          tx_valid_nxt = 1'b1;
          tx_byte_nxt  = in_ch.data.data_byte;
          sum_nxt      = sum_r + {8'h00, in_ch.data.data_byte};
          pos_nxt      = pos_r + POS_W'(1);
        end
      end
      fbus_pkg::OP_ACK: begin
        if (phase_r == fbus_pkg::PH_WAIT && ack_ok) begin
          if ((in_ch.data.rx_first == nf) && (in_ch.data.rx_second == ~nf)) begin
            frame_nxt = nf;
          end
          // pick the next packet length or finish
          if (sent_r < {1'b0, full_r}) begin
            len_nxt   = LEN_FULL;
            phase_nxt = fbus_pkg::PH_PKT;
            pos_nxt   = '0;
            sum_nxt   = 16'd0;
          end else if (sent_r == {1'b0, full_r} && rem_r != '0) begin
            len_nxt   = LEN_W'(rem_r);
            phase_nxt = fbus_pkg::PH_PKT;
            pos_nxt   = '0;
            sum_nxt   = 16'd0;
          end else begin
            phase_nxt = fbus_pkg::PH_OK;
          end
        end
      end
      fbus_pkg::OP_TICK: begin
        if (phase_r == fbus_pkg::PH_WAIT) begin
          if (timer_r != 16'hFFFF) begin
            timer_nxt = timer_r + 16'd1;
          end
          if (timer_nxt >= timeout_r) begin
            phase_nxt = fbus_pkg::PH_FAIL;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign due_nxt = file_due(phase_nxt, pos_nxt, len_nxt);

  // result fields
  always_comb begin
    out_nxt.tx_valid       = tx_valid_nxt;
    out_nxt.tx_byte        = tx_byte_nxt;
    out_nxt.want_file_byte = due_nxt;
    out_nxt.frame_number   = frame_nxt;
    case (phase_nxt)
      fbus_pkg::PH_CMD:  out_nxt.status = fbus_pkg::ST_SENDING;
      fbus_pkg::PH_PKT:  out_nxt.status = fbus_pkg::ST_SENDING;
      fbus_pkg::PH_WAIT: out_nxt.status = fbus_pkg::ST_WAITING;
      fbus_pkg::PH_OK:   out_nxt.status = fbus_pkg::ST_SUCCESS;
      fbus_pkg::PH_FAIL: out_nxt.status = fbus_pkg::ST_FAILED;
      default:           out_nxt.status = fbus_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baud_r    <= fbus_pkg::BAUD_RESET;
      timeout_r <= fbus_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fbus_pkg::REG_BAUD_WORD:   baud_r    <= cfg_wdata;
        fbus_pkg::REG_ACK_TIMEOUT: timeout_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fbus_pkg::PH_IDLE;
      frame_r <= 8'd0;
      sent_r  <= '0;
      full_r  <= '0;
      rem_r   <= '0;
      size_r  <= 32'd0;
      pos_r   <= '0;
      len_r   <= '0;
      sum_r   <= 16'd0;
      timer_r <= 16'd0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      frame_r <= frame_nxt;
      sent_r  <= sent_nxt;
      full_r  <= full_nxt;
      rem_r   <= rem_nxt;
      size_r  <= size_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      timer_r <= timer_nxt;
    end
  end

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_st_send   = (out_r.status == fbus_pkg::ST_SENDING);
  assign out_st_busy   = out_st_send || (out_r.status == fbus_pkg::ST_WAITING);
  assign ack_idle_fire = in_fire && (in_ch.data.operation == fbus_pkg::OP_ACK) &&
                         (phase_r != fbus_pkg::PH_WAIT);

  `FBUS_ASSERT_SAME(a_cmd_pos_range, phase_r == fbus_pkg::PH_CMD, pos_r < POS_CMD_END)
  `FBUS_ASSERT_SAME(a_tx_while_busy, out_valid_r && out_r.tx_valid, out_st_busy)
  `FBUS_ASSERT_SAME(a_want_only_sending, out_valid_r && out_r.want_file_byte, out_st_send)
  `FBUS_ASSERT_NEXT(a_ack_ignored, ack_idle_fire, $stable(frame_r) && $stable(phase_r))

endmodule

/* dv/tb_firmware_block_upload_sender.sv */
`timescale 1ns / 1ps

module tb_firmware_block_upload_sender;

  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  localparam int PKT_W      = fbus_pkg::PKT_W;
  localparam int POS_W      = fbus_pkg::POS_W;
  localparam int LEN_W      = fbus_pkg::LEN_W;
  localparam int CHUNK_LOG2 = fbus_pkg::CHUNK_LOG2;
  localparam int CFG_IDX_W  = fbus_pkg::CFG_IDX_W;

  // Tracks the upload state machine and holds the bytes it must put out.
  class upload_scoreboard;
    logic [31:0]           baud;
    logic [15:0]           timeout_ms;
    fbus_pkg::phase_t      ph;
    logic [7:0]            frame_no;
    logic [PKT_W:0]        pkts_sent;
    logic [PKT_W-1:0]      pkts_full;
    logic [CHUNK_LOG2-1:0] tail_len;
    logic [31:0]           file_len;
    logic [POS_W-1:0]      pos;
    logic [LEN_W-1:0]      pkt_len;
    logic [15:0]           csum;
    logic [15:0]           ms_waited;
    fbus_pkg::out_item_t   expected_tx[$];
    int unsigned           mismatches, checked, packets_done, uploads_ok, uploads_failed;

    function new();
      baud       = fbus_pkg::BAUD_RESET;
      timeout_ms = fbus_pkg::TIMEOUT_RESET;
      ph         = fbus_pkg::PH_IDLE;
      frame_no   = '0;
      pkts_sent  = '0;
      pkts_full  = '0;
      tail_len   = '0;
      file_len   = '0;
      pos        = '0;
      pkt_len    = '0;
      csum       = '0;
      ms_waited  = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        fbus_pkg::REG_BAUD_WORD:   baud = val;
        fbus_pkg::REG_ACK_TIMEOUT: timeout_ms = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] command_byte(int unsigned p);
      logic [7:0] s;
      case (p)
        0: return fbus_pkg::BYTE_SYNC;
        1: return fbus_pkg::BYTE_CMD;
        2, 3, 4, 5: return file_len[8*(5-p) +: 8];
        6, 7, 8, 9: return baud[8*(9-p) +: 8];
        10: begin
          s = fbus_pkg::BYTE_CMD
            + file_len[31:24] + file_len[23:16] + file_len[15:8] + file_len[7:0]
            + baud[31:24] + baud[23:16] + baud[15:8] + baud[7:0];
          return s;
        end
        12: return fbus_pkg::BYTE_TAIL;
        default: return fbus_pkg::BYTE_FILL;
      endcase
    endfunction

    function bit file_due();
      return ph == fbus_pkg::PH_PKT && pos >= 2 && int'(pos) < 2 + int'(pkt_len);
    endfunction

    function void open_packet();
      if (pkts_sent < pkts_full) begin
        pkt_len = LEN_W'(fbus_pkg::CHUNK_BYTES);
      end else if (pkts_sent == pkts_full && tail_len != 0) begin
        pkt_len = LEN_W'(tail_len);
      end else begin
        ph = fbus_pkg::PH_OK;
        return;
      end
      ph   = fbus_pkg::PH_PKT;
      pos  = '0;
      csum = '0;
    endfunction

    // Advance the state on one accepted item and queue the result it owes.
    function void note_item(fbus_pkg::in_item_t it);
      fbus_pkg::out_item_t res;
      fbus_pkg::phase_t    was;
      int                  p;
      logic [7:0]          nf;
      bit                  taken;
      was = ph;
      res = '0;
      case (it.operation)
        fbus_pkg::OP_START: begin
          file_len  = it.file_size;
          pkts_full = PKT_W'(it.file_size >> CHUNK_LOG2);
          tail_len  = it.file_size[CHUNK_LOG2-1:0];
          frame_no  = '0;
          pkts_sent = '0;
          pos       = '0;
          pkt_len   = '0;
          csum      = '0;
          ms_waited = '0;
          ph        = fbus_pkg::PH_CMD;
        end
        fbus_pkg::OP_SLOT: begin
          if (ph == fbus_pkg::PH_CMD) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = command_byte(32'(pos));
            pos++;
            if (pos >= fbus_pkg::CMD_LEN) begin
              ph        = fbus_pkg::PH_WAIT;
              ms_waited = '0;
            end
          end else if (ph == fbus_pkg::PH_PKT && !file_due()) begin
            p = int'(pos);
            res.tx_valid = 1'b1;
            if (p == 0)                             res.tx_byte = frame_no;
            else if (p == 1)                        res.tx_byte = ~frame_no;
            else if (p < 2 + fbus_pkg::CHUNK_BYTES)  res.tx_byte = '0;
            else if (p == 2 + fbus_pkg::CHUNK_BYTES) res.tx_byte = ~csum[15:8];
            else                                    res.tx_byte = ~csum[7:0];
            if (p < 2 + fbus_pkg::CHUNK_BYTES) csum = csum + res.tx_byte;
            pos++;
            if (p >= 3 + fbus_pkg::CHUNK_BYTES) begin
              pkts_sent++;
              packets_done++;
              ph        = fbus_pkg::PH_WAIT;
              ms_waited = '0;
            end
          end
        end
        fbus_pkg::OP_FILE: begin
          if (file_due()) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = it.data_byte;
            csum = csum + it.data_byte;
            pos++;
          end
        end
        fbus_pkg::OP_ACK: begin
          if (ph == fbus_pkg::PH_WAIT) begin
            nf    = frame_no + 8'd1;
            taken = (it.rx_first == fbus_pkg::BYTE_ACK);
            if (it.rx_first == nf && it.rx_second == ~nf) begin
              frame_no = nf;
              taken    = 1'b1;
            end
            if (taken) open_packet();
          end
        end
        fbus_pkg::OP_TICK: begin
          if (ph == fbus_pkg::PH_WAIT) begin
            if (ms_waited != 16'hFFFF) ms_waited++;
            if (ms_waited >= timeout_ms) ph = fbus_pkg::PH_FAIL;
          end
        end
        default: ;
      endcase
      if (ph == fbus_pkg::PH_OK && was != fbus_pkg::PH_OK) uploads_ok++;
      if (ph == fbus_pkg::PH_FAIL && was != fbus_pkg::PH_FAIL) uploads_failed++;
      case (ph)
        fbus_pkg::PH_CMD, fbus_pkg::PH_PKT: res.status = fbus_pkg::ST_SENDING;
        fbus_pkg::PH_WAIT:                  res.status = fbus_pkg::ST_WAITING;
        fbus_pkg::PH_OK:                    res.status = fbus_pkg::ST_SUCCESS;
        fbus_pkg::PH_FAIL:                  res.status = fbus_pkg::ST_FAILED;
        default:                            res.status = fbus_pkg::ST_IDLE;
      endcase
      res.want_file_byte = file_due();
      res.frame_number   = frame_no;
      expected_tx.push_back(res);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at result %0d: %s", checked, msg);
    endtask

    task check_result(fbus_pkg::out_item_t got);
      fbus_pkg::out_item_t want;
      if (expected_tx.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", got));
        return;
      end
      want = expected_tx.pop_front();
      if (got.tx_valid !== want.tx_valid)
        report_mismatch($sformatf("tx_valid %b, want %b", got.tx_valid, want.tx_valid));
      if (got.tx_byte !== want.tx_byte)
        report_mismatch($sformatf("tx_byte %h, want %h", got.tx_byte, want.tx_byte));
      if (got.want_file_byte !== want.want_file_byte)
        report_mismatch($sformatf("want_file_byte %b, want %b",
                                  got.want_file_byte, want.want_file_byte));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.frame_number !== want.frame_number)
        report_mismatch($sformatf("frame_number %h, want %h",
                                  got.frame_number, want.frame_number));
      checked++;
    endtask

    task check_leftovers();
      if (expected_tx.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_tx.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;

  fbus_in_if  in_if ();
  fbus_out_if out_if ();

  firmware_block_upload_sender uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  upload_scoreboard sb;
  int unsigned src_idle_pct, sink_idle_pct;
  int unsigned items_sent, hold_left, cycle_count;
  bit          hold_next, hold_req;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Result side: random stalls plus one long hold on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  function automatic fbus_pkg::in_item_t random_item(logic [2:0] op);
    fbus_pkg::in_item_t it;
    it.operation = op;
    it.file_size = $urandom();
    it.data_byte = 8'($urandom());
    it.rx_first  = 8'($urandom());
    it.rx_second = 8'($urandom());
    return it;
  endfunction

  function automatic fbus_pkg::in_item_t ack_or_tick();
    fbus_pkg::in_item_t it;
    int unsigned        r;
    logic [7:0]         nf;
    r  = $urandom_range(99);
    nf = sb.frame_no + 8'd1;
    if (r < 10) return random_item(fbus_pkg::OP_TICK);
    it = random_item(fbus_pkg::OP_ACK);
    if (r < 50) begin
      it.rx_first = fbus_pkg::BYTE_ACK;
    end else if (r < 90) begin
      it.rx_first  = nf;
      it.rx_second = ~nf;
    end
    return it;
  endfunction

  function automatic logic [31:0] pick_size(bit whole);
    int unsigned r;
    r = $urandom_range(99);
    if (whole) begin
      if (r < 20) return 32'd0;
      if (r < 80) return $urandom_range(1, 40);
      return 32'(fbus_pkg::CHUNK_BYTES);
    end
    if (r < 15) return 32'd0;
    if (r < 50) return $urandom_range(1, 40);
    if (r < 65)
      return 32'(fbus_pkg::CHUNK_BYTES * $urandom_range(1, 4) + $urandom_range(0, 3));
    return $urandom();
  endfunction

  // Called and returns just after a falling edge; holds valid until the transfer.
  task automatic push_item(input fbus_pkg::in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(it);
    items_sent++;
    if (hold_next) begin
      hold_req  = 1'b1;
      hold_next = 1'b0;
    end
    @(negedge clk);
  endtask

  task automatic push_op(input logic [2:0] op);
    push_item(random_item(op));
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.expected_tx.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_regs(input logic [31:0] baud, input logic [31:0] timeout);
    cfg_we    <= 1'b1;
    cfg_index <= fbus_pkg::REG_BAUD_WORD;
    cfg_wdata <= baud;
    @(negedge clk);
    cfg_index <= fbus_pkg::REG_ACK_TIMEOUT;
    cfg_wdata <= timeout;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(fbus_pkg::REG_BAUD_WORD, baud);
    sb.write_reg(fbus_pkg::REG_ACK_TIMEOUT, timeout);
  endtask

  // One upload driven from the tracked state, with stray items mixed in.
  task automatic run_upload(input logic [31:0] file_size, input int unsigned budget);
    fbus_pkg::in_item_t it;
    int unsigned        n;
    it = random_item(fbus_pkg::OP_START);
    it.file_size = file_size;
    push_item(it);
    n = 0;
    while (n < budget && !(sb.ph inside {fbus_pkg::PH_OK, fbus_pkg::PH_FAIL})) begin
      if ($urandom_range(99) < 6)         it = random_item(3'($urandom_range(1, 7)));
      else if (sb.ph == fbus_pkg::PH_WAIT) it = ack_or_tick();
      else if (sb.file_due())             it = random_item(fbus_pkg::OP_FILE);
      else                                it = random_item(fbus_pkg::OP_SLOT);
      push_item(it);
      n++;
    end
    if (sb.ph inside {fbus_pkg::PH_OK, fbus_pkg::PH_FAIL})
      repeat ($urandom_range(0, 2)) push_op(3'($urandom_range(1, 7)));
  endtask

  task automatic run_phase(input int unsigned quota);
    int unsigned first_item, left;
    first_item = items_sent;
    while (items_sent - first_item < quota) begin
      left = quota - (items_sent - first_item);
      if ($urandom_range(99) < 25) run_upload(pick_size(1'b1), left);
      else                         run_upload(pick_size(1'b0), $urandom_range(1, 60));
    end
  endtask

  task automatic directed_checks();
    fbus_pkg::in_item_t it;
    // Everything but start is dropped while idle.
    push_op(fbus_pkg::OP_TICK);
    push_op(fbus_pkg::OP_ACK);
    push_op(fbus_pkg::OP_SLOT);
    push_op(fbus_pkg::OP_FILE);
    push_op(3'($urandom_range(5, 7)));
    it = '1;
    it.operation = fbus_pkg::OP_START;
    push_item(it);
    push_op(fbus_pkg::OP_SLOT);
    push_op(fbus_pkg::OP_SLOT);
    // Restart mid-command with an empty file.
    it = '0;
    it.operation = fbus_pkg::OP_START;
    push_item(it);
    repeat (fbus_pkg::CMD_LEN) push_op(fbus_pkg::OP_SLOT);
    push_op(fbus_pkg::OP_FILE);
    push_op(fbus_pkg::OP_TICK);
    it = random_item(fbus_pkg::OP_ACK);
    it.rx_first  = 8'd1;
    it.rx_second = 8'd0;
    push_item(it);
    it.rx_second = 8'hFE;
    push_item(it);
    push_op(fbus_pkg::OP_SLOT);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    sb = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    src_idle_pct  = 19;
    sink_idle_pct = 47;
    directed_checks();
    drain_results();

    // Zero timeout: the first tick while waiting fails the upload.
    write_regs(32'h0000_0000, 32'h0000_0000);
    run_phase(RANDOM_ITEMS / 3);
    drain_results();

    src_idle_pct  = 47;
    sink_idle_pct = 19;
    write_regs(32'hFFFF_FFFF, {16'($urandom()), 16'd3});
    run_phase(RANDOM_ITEMS / 3);
    drain_results();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_regs($urandom(), 32'h0000_FFFF);
    hold_next = 1'b1;
    run_phase(RANDOM_ITEMS / 3);
    drain_results();

    sb.check_leftovers();
    $display("%0d transfers in, %0d results checked, %0d data packets closed",
             items_sent, sb.checked, sb.packets_done);
    $display("%0d uploads finished, %0d timed out, over three handshake mixes",
             sb.uploads_ok, sb.uploads_failed);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
